@@ rtl/pru_pkg.sv @@
// Shared constants and register map for the pixel replicate upscaler.
package pru_pkg;

    // Line buffer depth and largest factor by default
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_SCALE_DEF = 8;

    // Fixed field widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int SCALE_W    = 4;
    localparam int IN_WIDTH_W = 11;
    localparam int PAD_W      = 2;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-1:0] ADDR_SCALE    = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_IN_WIDTH = 3'd4;

    localparam logic [SCALE_W-1:0]    SCALE_RST    = 4'd1;
    localparam logic [IN_WIDTH_W-1:0] IN_WIDTH_RST = 11'd1;

    // Request kinds
    localparam logic REQ_CAPTURE = 1'b0;
    localparam logic REQ_REPLAY  = 1'b1;

endpackage

@@ rtl/pru_if.sv @@
// Valid/ready channel interfaces for input requests and output pixels.
interface pru_in_if
    import pru_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            req_type;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, req_type, red, green, blue, input ready);
    modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface pru_out_if
    import pru_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             row_end;
    logic [PAD_W-1:0] pad_bytes;
    logic             rejected;
    logic             last;

    modport source (output valid, out_red, out_green, out_blue, row_end, pad_bytes,
                    rejected, last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, row_end, pad_bytes,
                    rejected, last, output ready);
endinterface

@@ rtl/pixel_replicate_upscaler.sv @@
// Nearest-neighbor integer upscaler. Each capture transaction (req_type 0) stores its
// pixel in the line buffer and yields scale copies; once a row is captured and scale
// is above 1, scale-1 replay passes follow, each replay transaction (req_type 1)
// reading one stored pixel back and yielding scale copies. A request of the wrong
// kind yields one result flagged rejected. Results leave at one per cycle while the
// output is ready; an item yields max(1, scale) copies, counted by the copy counter
// of the output stage, and a new request is taken every cycle while that stage keeps
// up. A request passes through stage one (line buffer read), then the output
// register, before its first result. The line buffer needs no initialization after
// reset. scale and in_width are written through the APB port at byte addresses 0 and 4.
module pixel_replicate_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_SCALE = MAX_SCALE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pru_in_if.sink                i_pix,
    pru_out_if.source             o_pix,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WW > IN_WIDTH_W) ? WW : IN_WIDTH_W;
    localparam int SCW   = $clog2(MAX_SCALE + 1);
    localparam int SCMP  = (SCW > SCALE_W) ? SCW : SCALE_W;
    localparam int PW    = (MAX_SCALE > 2) ? $clog2(MAX_SCALE - 1) : 1;

    // Configuration registers
    logic [SCALE_W-1:0]    r_scale;
    logic [IN_WIDTH_W-1:0] r_in_width;

    // Row and phase tracking
    logic [CW-1:0] r_col;
    logic [PW-1:0] r_pass;
    logic          r_replaying;

    // Stage one: accepted request, line buffer read in flight
    logic             r_s1_valid;
    logic             r_s1_rej;
    logic             r_s1_replay;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_row_end;
    logic [PAD_W-1:0] r_s1_pad;
    logic [SCW-1:0]   r_s1_scale;

    // Output stage: copy emitter
    logic             r_em_valid;
    logic             r_em_rej;
    logic [PIX_W-1:0] r_em_pix;
    logic             r_em_row_end;
    logic [PAD_W-1:0] r_em_pad;
    logic [SCW-1:0]   r_em_scale;
    logic [SCW-1:0]   r_em_cnt;

    logic             apb_we;
    logic [SCMP-1:0]  eff_s_x;
    logic [SCW-1:0]   eff_s;
    logic [CMPW-1:0]  eff_w_x;
    logic [3:0]       pad_prod;
    logic [PAD_W-1:0] pad;
    logic             row_done;
    logic             pass_done;
    logic             in_fire;
    logic             req;
    logic             rej;
    logic             out_fire;
    logic             em_last;
    logic             em_free;
    logic             s1_move;
    logic             ram_we;
    logic             ram_re;
    logic [PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] in_pix;

    // APB write decode
    assign pready = 1'b1;
    assign apb_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_RST;
            r_in_width <= IN_WIDTH_RST;
        end else if (apb_we) begin
            unique case (paddr)
                ADDR_SCALE:    r_scale    <= pwdata[SCALE_W-1:0];
                ADDR_IN_WIDTH: r_in_width <= pwdata[IN_WIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    // APB read mux
    always_comb begin
        unique case (paddr)
            ADDR_SCALE:    prdata = APB_DATA_W'(r_scale);
            ADDR_IN_WIDTH: prdata = APB_DATA_W'(r_in_width);
            default:       prdata = '0;
        endcase
    end

    // Clamp factor and width into their supported ranges
    always_comb begin
        eff_s_x = SCMP'(r_scale);
        if (eff_s_x == '0) begin
            eff_s_x = SCMP'(1);
        end else if (eff_s_x > SCMP'(MAX_SCALE)) begin
            eff_s_x = SCMP'(MAX_SCALE);
        end
        eff_w_x = CMPW'(r_in_width);
        if (eff_w_x == '0) begin
            eff_w_x = CMPW'(1);
        end else if (eff_w_x > CMPW'(MAX_WIDTH)) begin
            eff_w_x = CMPW'(MAX_WIDTH);
        end
    end

    assign eff_s = eff_s_x[SCW-1:0];

    // Padding equals (out_width mod 4), since 3 is -1 modulo 4
    assign pad_prod = {2'b00, eff_w_x[1:0]} * {2'b00, eff_s_x[1:0]};
    assign pad      = pad_prod[PAD_W-1:0];

    assign row_done  = (CMPW'(r_col) + CMPW'(1)) >= eff_w_x;
    assign pass_done = (SCMP'(r_pass) + SCMP'(1)) >= (eff_s_x - SCMP'(1));

    // Handshakes
    assign em_last  = r_em_rej || (r_em_cnt == r_em_scale - SCW'(1));
    assign out_fire = o_pix.valid && o_pix.ready;
    assign em_free  = !r_em_valid || (out_fire && em_last);
    assign s1_move  = r_s1_valid && em_free;

    assign i_pix.ready = !r_s1_valid || s1_move;
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign req         = i_pix.req_type;
    assign rej         = (req == REQ_REPLAY) != r_replaying;
    assign in_pix      = {i_pix.red, i_pix.green, i_pix.blue};

    // Line buffer: write on capture, read on replay
    assign ram_we = in_fire && !rej && (req == REQ_CAPTURE);
    assign ram_re = in_fire && !rej && (req == REQ_REPLAY);

    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (in_pix),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Advance column, pass and phase on each matching request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_pass      <= '0;
            r_replaying <= 1'b0;
        end else if (in_fire && !rej) begin
            if (row_done) begin
                r_col <= '0;
                if (req == REQ_CAPTURE) begin
                    r_pass      <= '0;
                    r_replaying <= (eff_s > SCW'(1));
                end else if (pass_done) begin
                    r_pass      <= '0;
                    r_replaying <= 1'b0;
                end else begin
                    r_pass <= r_pass + PW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload; a rejected request carries a zero pixel
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_rej     <= rej;
            r_s1_replay  <= !rej && (req == REQ_REPLAY);
            r_s1_pix     <= rej ? '0 : in_pix;
            r_s1_row_end <= !rej && row_done;
            r_s1_pad     <= pad;
            r_s1_scale   <= rej ? SCW'(1) : eff_s;
        end
    end

    // Output stage control: load a new item or step through its copies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
        end else if (s1_move) begin
            r_em_valid <= 1'b1;
        end else if (out_fire && em_last) begin
            r_em_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_em_cnt <= '0;
        end else if (out_fire) begin
            r_em_cnt <= r_em_cnt + SCW'(1);
        end
    end

    // Output stage payload; replay pixels come straight from the buffer read
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_em_rej     <= r_s1_rej;
            r_em_pix     <= r_s1_replay ? ram_rdata : r_s1_pix;
            r_em_row_end <= r_s1_row_end;
            r_em_pad     <= r_s1_pad;
            r_em_scale   <= r_s1_scale;
        end
    end

    // Drive the result channel
    assign o_pix.valid     = r_em_valid;
    assign o_pix.out_red   = r_em_pix[3*CH_W-1:2*CH_W];
    assign o_pix.out_green = r_em_pix[2*CH_W-1:CH_W];
    assign o_pix.out_blue  = r_em_pix[CH_W-1:0];
    assign o_pix.row_end   = r_em_row_end && em_last;
    assign o_pix.pad_bytes = (r_em_row_end && em_last) ? r_em_pad : '0;
    assign o_pix.rejected  = r_em_rej;
    assign o_pix.last      = em_last;

endmodule

@@ rtl/pru_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/pixel_replicate_upscaler_tb.sv @@
// Self-checking testbench for the pixel replicate upscaler: scoreboard, drivers, stimulus.
`timescale 1ns / 100ps

module pixel_replicate_upscaler_tb;
    import pru_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 360;
    localparam int PHASES = 4;
    localparam int WIDE_ITEMS = 40;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             row_end;
        logic [PAD_W-1:0] pad_bytes;
        logic             rejected;
        logic             last;
    } t_pixel_result;

    // Mirror of the upscaler: line buffer, row position, replay state and registers
    class upscale_scoreboard;
        logic [PIX_W-1:0]    line_buf [MAX_WIDTH_DEF];
        bit [9:0]            col;
        bit [2:0]            pass_cnt;
        bit                  in_replay;
        bit [SCALE_W-1:0]    scale_reg;
        bit [IN_WIDTH_W-1:0] width_reg;
        t_pixel_result       expected_q [$];
        int unsigned         mismatches;
        int unsigned         requests;
        int unsigned         rejects;
        int unsigned         results;
        int unsigned         row_ends;

        function void restart();
            col = '0;
            pass_cnt = '0;
            in_replay = 1'b0;
            scale_reg = SCALE_RST;
            width_reg = IN_WIDTH_RST;
            expected_q.delete();
        endfunction

        function int unsigned eff_scale();
            if (scale_reg == 0) return 1;
            if (scale_reg > MAX_SCALE_DEF) return MAX_SCALE_DEF;
            return scale_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
        endfunction

        function string fmt(t_pixel_result r);
            return $sformatf("rgb=%02h%02h%02h row_end=%b pad=%0d rej=%b last=%b",
                r.red, r.green, r.blue, r.row_end, r.pad_bytes, r.rejected, r.last);
        endfunction

        function void write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
            if (addr == ADDR_SCALE) scale_reg = data[SCALE_W-1:0];
            else if (addr == ADDR_IN_WIDTH) width_reg = data[IN_WIDTH_W-1:0];
        endfunction

        // Queue the copies one accepted request produces and advance the row state
        function void note_request(logic req, logic [PIX_W-1:0] pix);
            int unsigned s;
            int unsigned w;
            int unsigned pad;
            int unsigned k;
            bit row_done;
            logic [PIX_W-1:0] val;
            t_pixel_result r;
            s = eff_scale();
            w = eff_width();
            pad = (4 - (3 * w * s) % 4) % 4;
            requests++;
            if ((req == REQ_REPLAY) != in_replay) begin
                r = '0;
                r.rejected = 1'b1;
                r.last = 1'b1;
                expected_q.push_back(r);
                rejects++;
                return;
            end
            row_done = (col + 1 >= w);
            if (req == REQ_CAPTURE) begin
                line_buf[col] = pix;
                val = pix;
            end else begin
                val = line_buf[col];
            end
            for (k = 0; k < s; k++) begin
                r.red = val[23:16];
                r.green = val[15:8];
                r.blue = val[7:0];
                r.last = (k == s - 1);
                r.row_end = r.last && row_done;
                r.pad_bytes = r.row_end ? pad[PAD_W-1:0] : '0;
                r.rejected = 1'b0;
                expected_q.push_back(r);
            end
            if (!row_done) begin
                col++;
            end else begin
                col = '0;
                if (req == REQ_CAPTURE) begin
                    pass_cnt = '0;
                    in_replay = (s > 1);
                end else if (pass_cnt + 1 >= s - 1) begin
                    pass_cnt = '0;
                    in_replay = 1'b0;
                end else begin
                    pass_cnt++;
                end
            end
        endfunction

        // Compare one output transaction with the oldest pending copy
        function void check_result(t_pixel_result got);
            t_pixel_result want;
            results++;
            if (got.row_end === 1'b1) row_ends++;
            if (expected_q.size() == 0) begin
                flag({"unexpected result ", fmt(got)});
                return;
            end
            want = expected_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.row_end !== want.row_end || got.pad_bytes !== want.pad_bytes ||
                got.rejected !== want.rejected || got.last !== want.last)
                flag({"expected ", fmt(want), " got ", fmt(got)});
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pru_in_if  pix_in ();
    pru_out_if pix_out ();

    upscale_scoreboard sb;
    int unsigned       src_idle_pct;
    int unsigned       sink_stall_pct;
    int unsigned       reg_writes;

    pixel_replicate_upscaler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Stall the output channel at random
    always @(posedge i_clk) begin
        pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every accepted output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
            sb.check_result({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                             pix_out.row_end, pix_out.pad_bytes, pix_out.rejected,
                             pix_out.last});
    end

    // Offer one request, idling first at random, and note it once accepted
    task automatic send_item(logic req, logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.req_type <= req;
        {pix_in.red, pix_in.green, pix_in.blue} <= pix;
        @(posedge i_clk);
        while (pix_in.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(req, pix);
    endtask

    // Send the kind the current phase wants, or the other kind as noise
    task automatic send_next(bit well_formed);
        logic req;
        req = well_formed ? sb.in_replay : !sb.in_replay;
        send_item(req, PIX_W'($urandom()));
    endtask

    // Hold off the sender until every pending copy has come out
    task automatic drain();
        pix_in.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register over APB, then read it back
    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, int unsigned field);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] wdata;
        mask = (addr == ADDR_SCALE) ? (1 << SCALE_W) - 1 : (1 << IN_WIDTH_W) - 1;
        wdata = field & mask;
        if ($urandom_range(1)) wdata = wdata | ($urandom() & ~mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.write_reg(addr, wdata);
        reg_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== (wdata & mask))
            sb.flag($sformatf("readback at %0d expected %0h got %0h", addr, wdata & mask,
                              prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick new settings; during replay the width may not grow
    task automatic retune();
        int unsigned pick;
        int unsigned val;
        drain();
        pick = $urandom_range(2);
        if (pick != 1) begin
            case ($urandom_range(9))
                0: val = 0;
                1: val = $urandom_range(9, 15);
                default: val = $urandom_range(1, 8);
            endcase
            reg_write(ADDR_SCALE, val);
        end
        if (pick != 0) begin
            if (sb.in_replay) begin
                val = $urandom_range(sb.eff_width(), 0);
            end else begin
                case ($urandom_range(9))
                    0: val = 0;
                    1: val = $urandom_range(7, 12);
                    default: val = $urandom_range(1, 6);
                endcase
            end
            reg_write(ADDR_IN_WIDTH, val);
        end
    endtask

    // Stall limit: far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int unsigned src_tbl [PHASES];
        int unsigned sink_tbl [PHASES];
        int unsigned ph;
        int unsigned n;
        int unsigned wait_cycles;
        src_tbl = '{0, 56, 0, 20};
        sink_tbl = '{0, 0, 56, 20};
        sb = new();
        sb.restart();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        reg_writes = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_in.valid <= 1'b0;
        pix_in.req_type <= REQ_CAPTURE;
        pix_in.red <= '0;
        pix_in.green <= '0;
        pix_in.blue <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one-pixel rows, extremes, replay while capturing
        send_item(REQ_CAPTURE, 24'h000000);
        send_item(REQ_CAPTURE, 24'hFFFFFF);
        send_item(REQ_REPLAY, 24'hFFFFFF);

        // Factor 3 over two pixels; wrong kinds mid-row and mid-replay
        drain();
        reg_write(ADDR_SCALE, 3);
        reg_write(ADDR_IN_WIDTH, 2);
        send_item(REQ_CAPTURE, 24'hFF00FF);
        send_item(REQ_REPLAY, 24'h123456);
        send_item(REQ_CAPTURE, 24'h00FF00);
        send_item(REQ_CAPTURE, 24'hA5A5A5);
        repeat (4) send_item(REQ_REPLAY, 24'h5A5A5A);

        // Out-of-range registers: scale 15 acts as 8, width 0 as 1
        drain();
        reg_write(ADDR_SCALE, 15);
        reg_write(ADDR_IN_WIDTH, 0);
        send_item(REQ_CAPTURE, 24'h0F1E2D);
        repeat (7) send_item(REQ_REPLAY, 24'h000000);

        // Scale 0 acts as 1; width cut mid-row ends the row early
        drain();
        reg_write(ADDR_SCALE, 0);
        reg_write(ADDR_IN_WIDTH, 3);
        send_item(REQ_CAPTURE, 24'h112233);
        drain();
        reg_write(ADDR_IN_WIDTH, 2);
        send_item(REQ_CAPTURE, 24'h445566);
        send_item(REQ_CAPTURE, 24'h778899);

        // Random phases with different idling; mostly well-formed rows
        for (ph = 0; ph < PHASES; ph++) begin
            src_idle_pct = src_tbl[ph];
            sink_stall_pct = sink_tbl[ph];
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if ($urandom_range(29) == 0) retune();
                send_next($urandom_range(9) != 0);
            end
        end

        // Long row under width 2047 (acts as 1024), then cut short by a narrower width
        src_idle_pct = 0;
        sink_stall_pct = 0;
        while (sb.in_replay || sb.col != 0) send_next(1'b1);
        drain();
        reg_write(ADDR_SCALE, 1);
        reg_write(ADDR_IN_WIDTH, 2047);
        repeat (WIDE_ITEMS) send_item(REQ_CAPTURE, PIX_W'($urandom()));
        drain();
        reg_write(ADDR_IN_WIDTH, WIDE_ITEMS);
        send_item(REQ_CAPTURE, PIX_W'($urandom()));
        pix_in.valid <= 1'b0;

        // Let the remaining copies out, then watch for strays
        wait_cycles = 0;
        while (sb.expected_q.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));

        $display("covered %0d requests (%0d rejected), %0d output pixels, %0d row ends",
                 sb.requests, sb.rejects, sb.results, sb.row_ends);
        $display("over %0d register writes and %0d idling phases", reg_writes, PHASES);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
